>>> hw/rtl/bsp_pkg.sv
`timescale 1ns / 1ps

package bsp_pkg;

   localparam int TEX_W         = 64;
   localparam int TEX_H         = 64;
   localparam int VERT_SHIFT    = 0;
   localparam int VERT_DIVISOR  = 1;
   localparam int HORIZ_DIVISOR = 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int DIV_W      = 64;
   localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

   // vertical shift numerator, VERT_SHIFT * 2^16
   localparam logic signed [63:0] VSHIFT_NUM = 64'(VERT_SHIFT * 65536);

   typedef enum logic {
      OP_SETUP = 1'b0,
      OP_PIXEL = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      REG_CAMERA_X   = 3'd0,
      REG_CAMERA_Y   = 3'd1,
      REG_VIEW_DIR_X = 3'd2,
      REG_VIEW_DIR_Y = 3'd3,
      REG_PLANE_X    = 3'd4,
      REG_PLANE_Y    = 3'd5,
      REG_SCREEN_W   = 3'd6,
      REG_SCREEN_H   = 3'd7
   } reg_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] sprite_x;
      logic signed [31:0] sprite_y;
      logic [2:0]         texture_id;
      logic [10:0]        stripe;
      logic [10:0]        row;
      logic [30:0]        column_depth;
   } item_type;

   typedef struct packed {
      logic signed [31:0] camera_x;
      logic signed [31:0] camera_y;
      logic signed [15:0] view_dir_x;
      logic signed [15:0] view_dir_y;
      logic signed [15:0] plane_x;
      logic signed [15:0] plane_y;
      logic [11:0]        screen_width;
      logic [11:0]        screen_height;
   } cfg_type;

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      logic [63:0] r;
      r = v[63] ? (~v + 64'd1) : v;
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic neg, input logic [63:0] mag);
      logic signed [31:0] r;
      if (neg) begin
         if (mag > 64'h0000_0000_8000_0000) r = {1'b1, 31'b0};
         else r = 32'(~mag + 64'd1);
      end else begin
         if (mag > 64'h0000_0000_7fff_ffff) r = {1'b0, {31{1'b1}}};
         else r = 32'(mag);
      end
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(input logic neg, input logic [63:0] mag);
      logic signed [15:0] r;
      if (neg) begin
         if (mag > 64'h8000) r = {1'b1, 15'b0};
         else r = 16'(~mag + 64'd1);
      end else begin
         if (mag > 64'h7fff) r = {1'b0, {15{1'b1}}};
         else r = 16'(mag);
      end
      return r;
   endfunction

   function automatic logic signed [15:0] satpos(input logic [63:0] mag);
      logic signed [15:0] r;
      if (mag > 64'h7fff) r = {1'b0, {15{1'b1}}};
      else r = 16'(mag);
      return r;
   endfunction

   // quotient truncated, then divided by 256 toward zero, low 12 bits
   function automatic logic [11:0] tex12(input logic neg, input logic [63:0] mag);
      logic [63:0] s;
      logic [11:0] r;
      s = mag >> 8;
      r = neg ? 12'(~s + 64'd1) : 12'(s);
      return r;
   endfunction

   function automatic logic signed [15:0] clamp16(input logic signed [18:0] v);
      logic signed [15:0] r;
      if (v > 19'sd32767) r = {1'b0, {15{1'b1}}};
      else if (v < -19'sd32768) r = {1'b1, 15'b0};
      else r = 16'(v);
      return r;
   endfunction

endpackage

>>> hw/rtl/billboard_sprite_projector_core.sv
`timescale 1ns / 1ps

// Billboard sprite projector for a raycaster.
// req_* beats go in with req_valid; the block holds req_stall high when its
// two-entry input queue is full. op 0 sets up a sprite (camera transform,
// depth, column, size, shift, clamped draw bounds); op 1 asks about one pixel
// (texel index and visible flag against the last setup).
// Every accepted beat yields exactly one rsp_* beat, in order. The result
// sits in an output register until rsp_stall is low; the next item keeps
// working meanwhile and waits only if that register is still full.
// Camera and screen registers are written on csr_* (csr_ready is always
// high); the user must write them only while no item is in flight, as the
// block does not enforce it. One item is worked at a time; its time goes
// mostly to the shared radix-2 divider, up to two quotients per pixel and
// up to six per setup.
// Reset (synchronous, active high) restores the default camera, a 640x480
// window and a cleared sprite, so pixels before a setup are not visible.

module billboard_sprite_projector_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic signed [31:0] req_sprite_x,
   input  logic signed [31:0] req_sprite_y,
   input  logic [2:0]         req_texture_id,
   input  logic [10:0]        req_stripe,
   input  logic [10:0]        req_row,
   input  logic [30:0]        req_column_depth,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_kind,
   output logic signed [15:0] rsp_start_x,
   output logic signed [15:0] rsp_end_x,
   output logic signed [15:0] rsp_start_y,
   output logic signed [15:0] rsp_end_y,
   output logic [11:0]        rsp_texel_index,
   output logic [2:0]         rsp_texture_out,
   output logic               rsp_visible
);

   bsp_pkg::cfg_type  cfg_ff, cfg_in;
   logic              q_valid, q_pop;
   bsp_pkg::item_type q_item;
   logic              csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (bsp_pkg::reg_type'(csr_index))
            bsp_pkg::REG_CAMERA_X:   cfg_in.camera_x      = csr_wdata;
            bsp_pkg::REG_CAMERA_Y:   cfg_in.camera_y      = csr_wdata;
            bsp_pkg::REG_VIEW_DIR_X: cfg_in.view_dir_x    = csr_wdata[15:0];
            bsp_pkg::REG_VIEW_DIR_Y: cfg_in.view_dir_y    = csr_wdata[15:0];
            bsp_pkg::REG_PLANE_X:    cfg_in.plane_x       = csr_wdata[15:0];
            bsp_pkg::REG_PLANE_Y:    cfg_in.plane_y       = csr_wdata[15:0];
            bsp_pkg::REG_SCREEN_W:   cfg_in.screen_width  = csr_wdata[11:0];
            bsp_pkg::REG_SCREEN_H:   cfg_in.screen_height = csr_wdata[11:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.camera_x      <= '0;
         cfg_ff.camera_y      <= '0;
         cfg_ff.view_dir_x    <= '0;
         cfg_ff.view_dir_y    <= 16'sd16384;
         cfg_ff.plane_x       <= 16'sd10813;
         cfg_ff.plane_y       <= '0;
         cfg_ff.screen_width  <= 12'd640;
         cfg_ff.screen_height <= 12'd480;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bsp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_sprite_x     (req_sprite_x),
      .req_sprite_y     (req_sprite_y),
      .req_texture_id   (req_texture_id),
      .req_stripe       (req_stripe),
      .req_row          (req_row),
      .req_column_depth (req_column_depth),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   bsp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_start_x     (rsp_start_x),
      .rsp_end_x       (rsp_end_x),
      .rsp_start_y     (rsp_start_y),
      .rsp_end_y       (rsp_end_y),
      .rsp_texel_index (rsp_texel_index),
      .rsp_texture_out (rsp_texture_out),
      .rsp_visible     (rsp_visible)
   );

endmodule

>>> hw/rtl/bsp_div.sv
`timescale 1ns / 1ps

module bsp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        busy,
   output logic        done,
   output logic [63:0] quo
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] den_ff, den_in;
   logic [bsp_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;

   logic [64:0] trial;
   logic [65:0] diff;
   logic        ge;

   // restoring division, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[63]};
   assign diff  = {1'b0, trial} - {2'b0, den_ff};
   assign ge    = ~diff[65];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = bsp_pkg::DIV_CNT_W'(bsp_pkg::DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[63:0] : trial[63:0];
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == bsp_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

>>> hw/rtl/bsp_front.sv
`timescale 1ns / 1ps

module bsp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic signed [31:0] req_sprite_x,
   input  logic signed [31:0] req_sprite_y,
   input  logic [2:0]         req_texture_id,
   input  logic [10:0]        req_stripe,
   input  logic [10:0]        req_row,
   input  logic [30:0]        req_column_depth,
   output logic               q_valid,
   output bsp_pkg::item_type  q_item,
   input  logic               q_pop
);

   bsp_pkg::item_type mem_ff [bsp_pkg::QUEUE_DEPTH];
   logic [bsp_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bsp_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [bsp_pkg::QCNT_W-1:0] count_ff, count_in;

   bsp_pkg::item_type item;
   logic push, pop;

   // classify the beat; fields that do not belong to the op are zeroed
   always_comb begin
      item = '0;
      item.op = (req_op == 1'b1) ? bsp_pkg::OP_PIXEL : bsp_pkg::OP_SETUP;
      if (item.op == bsp_pkg::OP_SETUP) begin
         item.sprite_x   = req_sprite_x;
         item.sprite_y   = req_sprite_y;
         item.texture_id = req_texture_id;
      end else begin
         item.stripe       = req_stripe;
         item.row          = req_row;
         item.column_depth = req_column_depth;
      end
   end

   assign req_stall = (count_ff == bsp_pkg::QCNT_W'(bsp_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == bsp_pkg::QPTR_W'(bsp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == bsp_pkg::QPTR_W'(bsp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) mem_ff[wr_ptr_ff] <= item;
   end

endmodule

>>> hw/rtl/bsp_back.sv
`timescale 1ns / 1ps

module bsp_back (
   input  logic               clock,
   input  logic               reset,
   input  bsp_pkg::cfg_type   cfg,
   input  logic               q_valid,
   input  bsp_pkg::item_type  q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_kind,
   output logic signed [15:0] rsp_start_x,
   output logic signed [15:0] rsp_end_x,
   output logic signed [15:0] rsp_start_y,
   output logic signed [15:0] rsp_end_y,
   output logic [11:0]        rsp_texel_index,
   output logic [2:0]         rsp_texture_out,
   output logic               rsp_visible
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_RELS, ST_PROD, ST_SUBS, ST_DIV_TX, ST_DIV_TY, ST_CHECK,
      ST_DIV_COL, ST_DIV_SH, ST_DIV_H, ST_DIV_W, ST_BOUNDS, ST_PIX,
      ST_PIX_X, ST_PIX_Y, ST_DONE
   } state_type;

   localparam logic signed [39:0] XSCALE = 40'(256 * bsp_pkg::TEX_W);
   localparam logic signed [39:0] YSCALE = 40'(bsp_pkg::TEX_H);
   localparam logic [36:0]        VDIV   = 37'(bsp_pkg::VERT_DIVISOR);
   localparam logic [36:0]        HDIV   = 37'(bsp_pkg::HORIZ_DIVISOR);
   localparam logic [11:0]        TEXW12 = 12'(bsp_pkg::TEX_W);

   state_type state_ff, state_in;
   logic launched_ff, launched_in;
   bsp_pkg::item_type item_ff, item_in;

   logic signed [32:0] rx_ff, rx_in, ry_ff, ry_in;
   logic signed [48:0] p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in, p3_ff, p3_in;
   logic signed [31:0] p4_ff, p4_in, p5_ff, p5_in;
   logic signed [63:0] numtx_ff, numtx_in, numty_ff, numty_in;
   logic signed [32:0] det_ff, det_in;
   logic signed [31:0] tx_ff, tx_in, ty_ff, ty_in;
   logic signed [44:0] colnum_ff, colnum_in;
   logic signed [39:0] numx_ff, numx_in, numy_ff, numy_in;
   logic vis_ff, vis_in;
   logic [11:0] texx_ff, texx_in, texy_ff, texy_in;

   // sprite state
   logic signed [31:0] sdepth_ff, sdepth_in;
   logic signed [15:0] scol_ff, scol_in, sheight_ff, sheight_in;
   logic signed [15:0] swidth_ff, swidth_in, sshift_ff, sshift_in;
   logic signed [15:0] bsx_ff, bsx_in, bex_ff, bex_in, bsy_ff, bsy_in, bey_ff, bey_in;
   logic [2:0] tex_ff, tex_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_kind_ff, rsp_kind_in;
   logic signed [15:0] rsx_ff, rsx_in, rex_ff, rex_in, rsy_ff, rsy_in, rey_ff, rey_in;
   logic [11:0] rtexel_ff, rtexel_in;
   logic [2:0] rtex_ff, rtex_in;
   logic rvis_ff, rvis_in;

   logic        div_start, div_busy, div_done, div_neg;
   logic [63:0] div_num, div_den, div_quo;

   logic [10:0] half_w, half_h;
   logic [31:0] aty;
   logic signed [32:0] tsum;
   logic signed [32:0] det_w;
   logic signed [18:0] hh, hw19, h2, w2, sh19, col19, big_h, big_w;
   logic signed [18:0] vsy, vey, vsx, vex;
   logic signed [19:0] off;
   logic signed [29:0] dval;
   logic signed [16:0] sx17, rw17;
   logic vis_w;
   logic [11:0] texel_w;

   bsp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign half_w = cfg.screen_width[11:1];
   assign half_h = cfg.screen_height[11:1];
   assign aty    = ty_ff[31] ? (~ty_ff + 32'd1) : ty_ff;
   assign tsum   = 33'(tx_ff) + 33'(ty_ff);
   assign det_w  = 33'(p4_ff) - 33'(p5_ff);

   // draw bounds
   assign hh    = 19'($signed({1'b0, half_h}));
   assign hw19  = 19'($signed({1'b0, half_w}));
   assign h2    = 19'($signed({1'b0, sheight_ff[15:1]}));
   assign w2    = 19'($signed({1'b0, swidth_ff[15:1]}));
   assign sh19  = 19'(sshift_ff);
   assign col19 = 19'(scol_ff);
   assign big_h = 19'($signed({1'b0, cfg.screen_height}));
   assign big_w = 19'($signed({1'b0, cfg.screen_width}));
   assign vsy   = hh + sh19 - h2;
   assign vey   = hh + sh19 + h2;
   assign vsx   = col19 - w2;
   assign vex   = col19 + w2;

   // pixel prep
   assign off  = 20'($signed({1'b0, item_ff.stripe})) - (20'(scol_ff) - 20'(w2));
   assign dval = ((30'($signed({1'b0, item_ff.row})) - 30'(sshift_ff)) <<< 8)
               - (30'($signed({1'b0, cfg.screen_height})) <<< 7)
               + (30'(sheight_ff) <<< 7);
   assign sx17 = 17'($signed({1'b0, item_ff.stripe}));
   assign rw17 = 17'($signed({1'b0, item_ff.row}));
   assign vis_w = (sx17 >= 17'(bsx_ff)) && (sx17 < 17'(bex_ff))
               && (rw17 >= 17'(bsy_ff)) && (rw17 < 17'(bey_ff))
               && (sdepth_ff > 32'sd0) && (item_ff.stripe != 11'd0)
               && ({1'b0, item_ff.stripe} < cfg.screen_width)
               && (33'(sdepth_ff) < $signed({2'b0, item_ff.column_depth}));
   assign texel_w = 12'(TEXW12 * texy_ff) + texx_ff;

   // divider operands per step
   always_comb begin
      div_num = '0;
      div_den = '0;
      div_neg = 1'b0;
      case (state_ff)
         ST_DIV_TX: begin
            div_num = bsp_pkg::mag64(numtx_ff);
            div_den = bsp_pkg::mag64(64'(det_ff));
            div_neg = numtx_ff[63] ^ det_ff[32];
         end
         ST_DIV_TY: begin
            div_num = bsp_pkg::mag64(numty_ff);
            div_den = bsp_pkg::mag64(64'(det_ff));
            div_neg = numty_ff[63] ^ det_ff[32];
         end
         ST_DIV_COL: begin
            div_num = bsp_pkg::mag64(64'(colnum_ff));
            div_den = {32'b0, aty};
            div_neg = colnum_ff[44] ^ ty_ff[31];
         end
         ST_DIV_SH: begin
            div_num = bsp_pkg::mag64(bsp_pkg::VSHIFT_NUM);
            div_den = {32'b0, aty};
            div_neg = bsp_pkg::VSHIFT_NUM[63] ^ ty_ff[31];
         end
         ST_DIV_H: begin
            div_num = {36'b0, cfg.screen_height, 16'b0};
            div_den = 64'(37'(aty) * VDIV);
         end
         ST_DIV_W: begin
            div_num = {36'b0, cfg.screen_height, 16'b0};
            div_den = 64'(37'(aty) * HDIV);
         end
         ST_PIX_X: begin
            div_num = bsp_pkg::mag64(64'(numx_ff));
            div_den = {48'b0, swidth_ff};
            div_neg = numx_ff[39];
         end
         ST_PIX_Y: begin
            div_num = bsp_pkg::mag64(64'(numy_ff));
            div_den = {48'b0, sheight_ff};
            div_neg = numy_ff[39];
         end
         default: begin
            div_num = '0;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      launched_in = launched_ff;
      item_in     = item_ff;
      rx_in = rx_ff;  ry_in = ry_ff;
      p0_in = p0_ff;  p1_in = p1_ff;  p2_in = p2_ff;  p3_in = p3_ff;
      p4_in = p4_ff;  p5_in = p5_ff;
      numtx_in = numtx_ff;  numty_in = numty_ff;  det_in = det_ff;
      tx_in = tx_ff;  ty_in = ty_ff;  colnum_in = colnum_ff;
      numx_in = numx_ff;  numy_in = numy_ff;  vis_in = vis_ff;
      texx_in = texx_ff;  texy_in = texy_ff;
      sdepth_in = sdepth_ff;  scol_in = scol_ff;  sheight_in = sheight_ff;
      swidth_in = swidth_ff;  sshift_in = sshift_ff;
      bsx_in = bsx_ff;  bex_in = bex_ff;  bsy_in = bsy_ff;  bey_in = bey_ff;
      tex_in = tex_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsx_in = rsx_ff;  rex_in = rex_ff;  rsy_in = rsy_ff;  rey_in = rey_ff;
      rtexel_in = rtexel_ff;  rtex_in = rtex_ff;  rvis_in = rvis_ff;
      q_pop     = 1'b0;
      div_start = 1'b0;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_item;
               if (q_item.op == bsp_pkg::OP_SETUP) begin
                  tex_in   = q_item.texture_id;
                  state_in = ST_RELS;
               end else begin
                  state_in = ST_PIX;
               end
            end
         end
         ST_RELS: begin
            rx_in    = 33'(item_ff.sprite_x) - 33'(cfg.camera_x);
            ry_in    = 33'(item_ff.sprite_y) - 33'(cfg.camera_y);
            state_in = ST_PROD;
         end
         ST_PROD: begin
            p0_in    = 49'(cfg.view_dir_y) * 49'(rx_ff);
            p1_in    = 49'(cfg.view_dir_x) * 49'(ry_ff);
            p2_in    = 49'(cfg.plane_x) * 49'(ry_ff);
            p3_in    = 49'(cfg.plane_y) * 49'(rx_ff);
            p4_in    = 32'(cfg.plane_x) * 32'(cfg.view_dir_y);
            p5_in    = 32'(cfg.view_dir_x) * 32'(cfg.plane_y);
            state_in = ST_SUBS;
         end
         ST_SUBS: begin
            numtx_in = {50'(p0_ff) - 50'(p1_ff), 14'b0};
            numty_in = {50'(p2_ff) - 50'(p3_ff), 14'b0};
            det_in   = det_w;
            if (det_w == 33'sd0) begin
               // singular camera
               tx_in    = '0;
               ty_in    = '0;
               state_in = ST_CHECK;
            end else begin
               state_in = ST_DIV_TX;
            end
         end
         ST_DIV_TX: begin
            if (!launched_ff) begin
               div_start   = 1'b1;
               launched_in = 1'b1;
            end else if (div_done) begin
               tx_in       = bsp_pkg::sat32(div_neg, div_quo);
               launched_in = 1'b0;
               state_in    = ST_DIV_TY;
            end
         end
         ST_DIV_TY: begin
            if (!launched_ff) begin
               div_start   = 1'b1;
               launched_in = 1'b1;
            end else if (div_done) begin
               ty_in       = bsp_pkg::sat32(div_neg, div_quo);
               launched_in = 1'b0;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            sdepth_in = ty_ff;
            if (ty_ff == 32'sd0) begin
               // sprite at the camera plane
               scol_in    = 16'(hw19);
               sshift_in  = '0;
               sheight_in = '0;
               swidth_in  = '0;
               state_in   = ST_BOUNDS;
            end else begin
               colnum_in = 45'(tsum) * 45'($signed({1'b0, half_w}));
               state_in  = ST_DIV_COL;
            end
         end
         ST_DIV_COL: begin
            if (!launched_ff) begin
               div_start   = 1'b1;
               launched_in = 1'b1;
            end else if (div_done) begin
               scol_in     = bsp_pkg::sat16(div_neg, div_quo);
               launched_in = 1'b0;
               state_in    = ST_DIV_SH;
            end
         end
         ST_DIV_SH: begin
            if (!launched_ff) begin
               div_start   = 1'b1;
               launched_in = 1'b1;
            end else if (div_done) begin
               sshift_in   = bsp_pkg::sat16(div_neg, div_quo);
               launched_in = 1'b0;
               state_in    = ST_DIV_H;
            end
         end
         ST_DIV_H: begin
            if (!launched_ff) begin
               div_start   = 1'b1;
               launched_in = 1'b1;
            end else if (div_done) begin
               sheight_in  = bsp_pkg::satpos(div_quo);
               launched_in = 1'b0;
               state_in    = ST_DIV_W;
            end
         end
         ST_DIV_W: begin
            if (!launched_ff) begin
               div_start   = 1'b1;
               launched_in = 1'b1;
            end else if (div_done) begin
               swidth_in   = bsp_pkg::satpos(div_quo);
               launched_in = 1'b0;
               state_in    = ST_BOUNDS;
            end
         end
         ST_BOUNDS: begin
            bsy_in   = bsp_pkg::clamp16((vsy < 19'sd0) ? 19'sd0 : vsy);
            bey_in   = bsp_pkg::clamp16((vey >= big_h) ? big_h - 19'sd1 : vey);
            bsx_in   = bsp_pkg::clamp16((vsx < 19'sd0) ? 19'sd0 : vsx);
            bex_in   = bsp_pkg::clamp16((vex >= big_w) ? big_w - 19'sd1 : vex);
            state_in = ST_DONE;
         end
         ST_PIX: begin
            numx_in  = 40'(off) * XSCALE;
            numy_in  = 40'(dval) * YSCALE;
            vis_in   = vis_w;
            state_in = ST_PIX_X;
         end
         ST_PIX_X: begin
            if (swidth_ff == 16'sd0) begin
               texx_in  = '0;
               state_in = ST_PIX_Y;
            end else if (!launched_ff) begin
               div_start   = 1'b1;
               launched_in = 1'b1;
            end else if (div_done) begin
               texx_in     = bsp_pkg::tex12(div_neg, div_quo);
               launched_in = 1'b0;
               state_in    = ST_PIX_Y;
            end
         end
         ST_PIX_Y: begin
            if (sheight_ff == 16'sd0) begin
               texy_in  = '0;
               state_in = ST_DONE;
            end else if (!launched_ff) begin
               div_start   = 1'b1;
               launched_in = 1'b1;
            end else if (div_done) begin
               texy_in     = bsp_pkg::tex12(div_neg, div_quo);
               launched_in = 1'b0;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = item_ff.op;
               rsx_in = bsx_ff;
               rex_in = bex_ff;
               rsy_in = bsy_ff;
               rey_in = bey_ff;
               rtex_in = tex_ff;
               if (item_ff.op == bsp_pkg::OP_SETUP) begin
                  rtexel_in = '0;
                  rvis_in   = 1'b0;
               end else begin
                  rtexel_in = texel_w;
                  rvis_in   = vis_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sdepth_ff  <= '0;
         scol_ff    <= '0;
         sheight_ff <= '0;
         swidth_ff  <= '0;
         sshift_ff  <= '0;
         bsx_ff <= '0;
         bex_ff <= '0;
         bsy_ff <= '0;
         bey_ff <= '0;
         tex_ff <= '0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
         sdepth_ff  <= sdepth_in;
         scol_ff    <= scol_in;
         sheight_ff <= sheight_in;
         swidth_ff  <= swidth_in;
         sshift_ff  <= sshift_in;
         bsx_ff <= bsx_in;
         bex_ff <= bex_in;
         bsy_ff <= bsy_in;
         bey_ff <= bey_in;
         tex_ff <= tex_in;
      end
      item_ff <= item_in;
      rx_ff <= rx_in;  ry_ff <= ry_in;
      p0_ff <= p0_in;  p1_ff <= p1_in;  p2_ff <= p2_in;  p3_ff <= p3_in;
      p4_ff <= p4_in;  p5_ff <= p5_in;
      numtx_ff <= numtx_in;  numty_ff <= numty_in;  det_ff <= det_in;
      tx_ff <= tx_in;  ty_ff <= ty_in;  colnum_ff <= colnum_in;
      numx_ff <= numx_in;  numy_ff <= numy_in;  vis_ff <= vis_in;
      texx_ff <= texx_in;  texy_ff <= texy_in;
      rsp_kind_ff <= rsp_kind_in;
      rsx_ff <= rsx_in;  rex_ff <= rex_in;  rsy_ff <= rsy_in;  rey_ff <= rey_in;
      rtexel_ff <= rtexel_in;  rtex_ff <= rtex_in;  rvis_ff <= rvis_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_start_x     = rsx_ff;
   assign rsp_end_x       = rex_ff;
   assign rsp_start_y     = rsy_ff;
   assign rsp_end_y       = rey_ff;
   assign rsp_texel_index = rtexel_ff;
   assign rsp_texture_out = rtex_ff;
   assign rsp_visible     = rvis_ff;

   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

   a_pop_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff != ST_IDLE)
      else $error("item popped but sequencer stayed idle");

   a_setup_result_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == bsp_pkg::OP_SETUP |-> rtexel_ff == '0 && !rvis_ff)
      else $error("setup result carries pixel data");

   a_size_nonneg: assert property (@(posedge clock) disable iff (reset)
      !sheight_ff[15] && !swidth_ff[15])
      else $error("sprite size went negative");

endmodule
